@@ sv/dsq_pkg.sv @@
// Shared types and constants for the deadline sorted queue.
// No dependencies; every other file refers to it by scoped names.
package dsq_pkg;

    localparam int FUNC_W     = 2;
    localparam int TAG_PORT_W = 8;
    localparam int DL_W       = 64;
    localparam int STATUS_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_MOVE   = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

endpackage

@@ sv/dsq_req_if.sv @@
// Request channel: valid/ready plus operation, tag and deadline.
// Depends on dsq_pkg for field widths.
interface dsq_req_if;
    logic                            valid;
    logic                            ready;
    logic [dsq_pkg::FUNC_W-1:0]      func;
    logic [dsq_pkg::TAG_PORT_W-1:0]  tag;
    logic [dsq_pkg::DL_W-1:0]        deadline;

    modport source (output valid, output func, output tag, output deadline, input ready);
    modport sink   (input valid, input func, input tag, input deadline, output ready);
endinterface

@@ sv/dsq_rsp_if.sv @@
// Response channel: valid/ready plus status, count and head entry.
// Depends on dsq_pkg for field widths; CNT_W follows the queue depth.
interface dsq_rsp_if #(
    parameter int CNT_W = 5
);
    logic                            valid;
    logic                            ready;
    logic [dsq_pkg::STATUS_W-1:0]    status;
    logic [CNT_W-1:0]                count;
    logic                            head_valid;
    logic [dsq_pkg::TAG_PORT_W-1:0]  head_tag;
    logic [dsq_pkg::DL_W-1:0]        head_deadline;

    modport source (output valid, output status, output count, output head_valid,
                    output head_tag, output head_deadline, input ready);
    modport sink   (input valid, input status, input count, input head_valid,
                    input head_tag, input head_deadline, output ready);
endinterface

@@ sv/dsq_store.sv @@
// Entry memory: one write port, one read port with registered read data.
// Depends on dsq_pkg for the deadline width.
module dsq_store #(
    parameter int DEPTH = 16,
    parameter int TAG_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [TAG_W-1:0]              i_wr_tag,
    input  logic [dsq_pkg::DL_W-1:0]      i_wr_deadline,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [TAG_W-1:0]              o_rd_tag,
    output logic [dsq_pkg::DL_W-1:0]      o_rd_deadline
);
    logic [TAG_W-1:0]          r_tag_mem [DEPTH];
    logic [dsq_pkg::DL_W-1:0]  r_dl_mem  [DEPTH];
    logic [TAG_W-1:0]          r_rd_tag;
    logic [dsq_pkg::DL_W-1:0]  r_rd_deadline;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_addr] <= i_wr_tag;
            r_dl_mem[i_wr_addr]  <= i_wr_deadline;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_tag      <= r_tag_mem[i_rd_addr];
            r_rd_deadline <= r_dl_mem[i_rd_addr];
        end
    end

    assign o_rd_tag      = r_rd_tag;
    assign o_rd_deadline = r_rd_deadline;
endmodule

@@ sv/dsq_cmp.sv @@
// Shared compare unit: deadline greater-than and tag equality.
// Depends on dsq_pkg for the deadline width.
module dsq_cmp #(
    parameter int TAG_W = 8
) (
    input  logic [TAG_W-1:0]          i_slot_tag,
    input  logic [dsq_pkg::DL_W-1:0]  i_slot_deadline,
    input  logic [TAG_W-1:0]          i_key_tag,
    input  logic [dsq_pkg::DL_W-1:0]  i_key_deadline,
    output logic                      o_later,
    output logic                      o_tag_eq
);
    // slot strictly later than the key: it moves up one place on insert
    assign o_later  = i_slot_deadline > i_key_deadline;
    assign o_tag_eq = i_slot_tag == i_key_tag;
endmodule

@@ sv/deadline_sorted_queue_unit.sv @@
// Insert scans from the tail over the entries with a later deadline; remove scans
// every entry held; move does a remove scan and then, unless the queue is full, an
// insert scan; func 3 or an insert into a full queue only fetches the head. One
// operation at a time; each scan step is a memory read plus one pass through the shared compare unit.
// Reset: synchronous active-low; clears fill count, sequencer and output valid.
// Entry memory is not cleared; scans read only slots below the fill count.
module deadline_sorted_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsq_req_if.sink     i_req,
    dsq_rsp_if.source   o_rsp
);
    localparam int CW = $clog2(DEPTH + 1);   // fill count, holds DEPTH itself
    localparam int IW = $clog2(DEPTH);       // memory index

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RM_RD  = 7'b0000010,   // remove scan: issue read or finish
        S_RM_CMP = 7'b0000100,   // remove scan: match tag / shift down
        S_IN_RD  = 7'b0001000,   // insert scan from the tail: issue read or place at 0
        S_IN_CMP = 7'b0010000,   // insert scan: shift up or place
        S_HD_RD  = 7'b0100000,   // fetch head entry
        S_OUT    = 7'b1000000    // load the output register
    } t_state;

    t_state                    r_state, n_state;
    dsq_pkg::t_func            r_func;
    logic [TAG_WIDTH-1:0]      r_tag;
    logic [dsq_pkg::DL_W-1:0]  r_deadline;
    dsq_pkg::t_status          r_status, n_status;
    logic [CW-1:0]             r_fill, n_fill;
    logic [CW-1:0]             r_idx, n_idx;
    logic                      r_found, n_found;

    logic                      r_out_valid;
    dsq_pkg::t_status          r_out_status;
    logic [CW-1:0]             r_out_count;
    logic                      r_out_head_valid;
    logic [TAG_WIDTH-1:0]      r_out_head_tag;
    logic [dsq_pkg::DL_W-1:0]  r_out_head_deadline;

    logic                      w_accept;
    logic                      w_load_out;
    logic [TAG_WIDTH-1:0]      w_req_tag;
    logic [CW-1:0]             w_idx_dec;

    logic                      w_rd_en;
    logic [IW-1:0]             w_rd_addr;
    logic                      w_wr_en;
    logic [IW-1:0]             w_wr_addr;
    logic                      w_wr_from_slot;   // move a stored entry vs. write the new one
    logic [TAG_WIDTH-1:0]      w_wr_tag;
    logic [dsq_pkg::DL_W-1:0]  w_wr_deadline;
    logic [TAG_WIDTH-1:0]      w_rd_tag;
    logic [dsq_pkg::DL_W-1:0]  w_rd_deadline;
    logic                      w_later;
    logic                      w_tag_eq;

    // Tag resized between the 8-bit port field and the stored TAG_WIDTH bits
    for (genvar b = 0; b < TAG_WIDTH; b++) begin : g_tag_in
        if (b < dsq_pkg::TAG_PORT_W) begin : g_bit
            assign w_req_tag[b] = i_req.tag[b];
        end else begin : g_zero
            assign w_req_tag[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < dsq_pkg::TAG_PORT_W; b++) begin : g_tag_out
        if (b < TAG_WIDTH) begin : g_bit
            assign o_rsp.head_tag[b] = r_out_head_tag[b];
        end else begin : g_zero
            assign o_rsp.head_tag[b] = 1'b0;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_idx_dec   = r_idx - 1'b1;

    // Entry memory and the shared compare unit
    dsq_store #(
        .DEPTH (DEPTH),
        .TAG_W (TAG_WIDTH)
    ) u_store (
        .i_clk         (i_clk),
        .i_wr_en       (w_wr_en),
        .i_wr_addr     (w_wr_addr),
        .i_wr_tag      (w_wr_tag),
        .i_wr_deadline (w_wr_deadline),
        .i_rd_en       (w_rd_en),
        .i_rd_addr     (w_rd_addr),
        .o_rd_tag      (w_rd_tag),
        .o_rd_deadline (w_rd_deadline)
    );

    dsq_cmp #(
        .TAG_W (TAG_WIDTH)
    ) u_cmp (
        .i_slot_tag      (w_rd_tag),
        .i_slot_deadline (w_rd_deadline),
        .i_key_tag       (r_tag),
        .i_key_deadline  (r_deadline),
        .o_later         (w_later),
        .o_tag_eq        (w_tag_eq)
    );

    assign w_wr_tag      = w_wr_from_slot ? w_rd_tag      : r_tag;
    assign w_wr_deadline = w_wr_from_slot ? w_rd_deadline : r_deadline;

    // Sequencer
    // Remove walks from the head; after the first tag match every following
    // entry is copied one slot down. Insert walks from the tail; each entry
    // strictly later than the new deadline is copied one slot up, and the new
    // entry lands in the gap, so it goes after equal deadlines.
    always_comb begin
        n_state        = r_state;
        n_status       = r_status;
        n_fill         = r_fill;
        n_idx          = r_idx;
        n_found        = r_found;
        w_rd_en        = 1'b0;
        w_rd_addr      = r_idx[IW-1:0];
        w_wr_en        = 1'b0;
        w_wr_addr      = r_idx[IW-1:0];
        w_wr_from_slot = 1'b0;
        w_load_out     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = dsq_pkg::ST_DONE;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    unique case (i_req.func)
                        dsq_pkg::FN_INSERT: begin
                            if (r_fill == CW'(DEPTH)) begin
                                n_status = dsq_pkg::ST_FULL;
                                n_state  = S_HD_RD;
                            end else begin
                                n_idx   = r_fill;
                                n_state = S_IN_RD;
                            end
                        end
                        dsq_pkg::FN_REMOVE,
                        dsq_pkg::FN_MOVE: begin
                            n_state = S_RM_RD;
                        end
                        default: begin
                            n_state = S_HD_RD;   // unused code: no operation
                        end
                    endcase
                end
            end
            S_RM_RD: begin
                if (r_idx == r_fill) begin
                    if (r_found) begin
                        n_fill = r_fill - 1'b1;
                    end else begin
                        n_status = dsq_pkg::ST_ABSENT;
                    end
                    if (r_func == dsq_pkg::FN_MOVE) begin
                        if (n_fill == CW'(DEPTH)) begin
                            n_status = dsq_pkg::ST_FULL;
                            n_state  = S_HD_RD;
                        end else begin
                            n_idx   = n_fill;
                            n_state = S_IN_RD;
                        end
                    end else begin
                        n_state = S_HD_RD;
                    end
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (r_found) begin
                    w_wr_en        = 1'b1;
                    w_wr_addr      = w_idx_dec[IW-1:0];
                    w_wr_from_slot = 1'b1;
                end else if (w_tag_eq) begin
                    n_found = 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_RM_RD;
            end
            S_IN_RD: begin
                if (r_idx == '0) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = '0;
                    n_fill    = r_fill + 1'b1;
                    n_state   = S_HD_RD;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx_dec[IW-1:0];
                    n_state   = S_IN_CMP;
                end
            end
            S_IN_CMP: begin
                w_wr_en = 1'b1;
                if (w_later) begin
                    w_wr_from_slot = 1'b1;
                    n_idx          = w_idx_dec;
                    n_state        = S_IN_RD;
                end else begin
                    n_fill  = r_fill + 1'b1;
                    n_state = S_HD_RD;
                end
            end
            S_HD_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // result waits here only while the previous one is still held
                if (!r_out_valid || o_rsp.ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        if (w_accept) begin
            r_func     <= dsq_pkg::t_func'(i_req.func);
            r_tag      <= w_req_tag;
            r_deadline <= i_req.deadline;
        end
    end

    // Output register: the next request may be taken while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status     <= r_status;
            r_out_count      <= r_fill;
            r_out_head_valid <= (r_fill != '0);
            if (r_fill != '0) begin
                r_out_head_tag      <= w_rd_tag;
                r_out_head_deadline <= w_rd_deadline;
            end else begin
                r_out_head_tag      <= '0;
                r_out_head_deadline <= '0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.count         = r_out_count;
    assign o_rsp.head_valid    = r_out_head_valid;
    assign o_rsp.head_deadline = r_out_head_deadline;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after a request transfer");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
            ((r_fill == CW'($past(r_fill) + 1'b1)) || (r_fill == CW'($past(r_fill) - 1'b1))))
        else $error("fill count moved by more than one");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ((r_state == S_RM_CMP) || (r_state == S_IN_RD) || (r_state == S_IN_CMP)))
        else $error("memory write outside a scan step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (!r_out_valid || o_rsp.ready))
        else $error("result loaded over an untaken one");
`endif
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for deadline_sorted_queue_unit: directed table, then random traffic.
// Depends on dsq_pkg, dsq_req_if, dsq_rsp_if and the queue unit itself.
module tb_top;

    localparam int DEPTH          = 16;
    localparam int TAG_WIDTH      = 8;
    localparam int FUNC_W         = dsq_pkg::FUNC_W;
    localparam int TAG_PORT_W     = dsq_pkg::TAG_PORT_W;
    localparam int DL_W           = dsq_pkg::DL_W;
    localparam int STATUS_W       = dsq_pkg::STATUS_W;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int TAG_MASK       = (1 << TAG_WIDTH) - 1;
    localparam int N_RANDOM       = 700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;   // worst move: full remove scan plus full insert scan
    // func code 3 is not in the package enum; the unit treats it as a no-op
    localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;
    localparam logic [DL_W-1:0]   DL_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [CNT_W-1:0]      count;
        logic                  head_valid;
        logic [TAG_PORT_W-1:0] head_tag;
        logic [DL_W-1:0]       head_deadline;
    } t_sched_rsp;

    typedef struct {
        logic [FUNC_W-1:0]     func;
        logic [TAG_PORT_W-1:0] tag;
        logic [DL_W-1:0]       deadline;
        bit                    typed;
        t_sched_rsp            want;
    } t_sched_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dsq_req_if                  req_if ();
    dsq_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

    deadline_sorted_queue_unit #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the sorted store
    logic [TAG_PORT_W-1:0] sq_tag [DEPTH];
    logic [DL_W-1:0]       sq_dl  [DEPTH];
    int                    sq_fill = 0;

    t_sched_rsp  predicted_rsp_q [$];
    t_sched_step dir_steps [$];

    int err_count     = 0;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int op_seen [4]   = '{0, 0, 0, 0};
    int rsp_seen      = 0;
    int full_drops    = 0;
    int absent_seen   = 0;
    int full_hits     = 0;
    int stall_cycles  = 0;

    // Insert after every entry with an equal or earlier deadline
    function automatic bit q_put(input logic [TAG_PORT_W-1:0] t, input logic [DL_W-1:0] dl);
        int pos;
        int i;
        pos = 0;
        if (sq_fill >= DEPTH) return 1'b0;
        while (pos < sq_fill && sq_dl[pos] <= dl) pos++;
        for (i = sq_fill; i > pos; i--) begin
            sq_tag[i] = sq_tag[i-1];
            sq_dl[i]  = sq_dl[i-1];
        end
        sq_tag[pos] = t;
        sq_dl[pos]  = dl;
        sq_fill++;
        return 1'b1;
    endfunction

    // First match from the head is deleted
    function automatic bit q_drop(input logic [TAG_PORT_W-1:0] t);
        int pos;
        int i;
        pos = 0;
        while (pos < sq_fill && sq_tag[pos] != t) pos++;
        if (pos >= sq_fill) return 1'b0;
        for (i = pos; i + 1 < sq_fill; i++) begin
            sq_tag[i] = sq_tag[i+1];
            sq_dl[i]  = sq_dl[i+1];
        end
        sq_fill--;
        return 1'b1;
    endfunction

    function automatic t_sched_rsp apply_sched_op(input logic [FUNC_W-1:0] f,
                                                  input logic [TAG_PORT_W-1:0] tg,
                                                  input logic [DL_W-1:0] dl);
        t_sched_rsp r;
        logic [TAG_PORT_W-1:0] t;
        t = tg & TAG_PORT_W'(TAG_MASK);
        r = '0;
        r.status = dsq_pkg::ST_DONE;
        case (f)
            dsq_pkg::FN_INSERT: if (!q_put(t, dl)) r.status = dsq_pkg::ST_FULL;
            dsq_pkg::FN_REMOVE: if (!q_drop(t)) r.status = dsq_pkg::ST_ABSENT;
            dsq_pkg::FN_MOVE: begin
                if (!q_drop(t)) r.status = dsq_pkg::ST_ABSENT;
                if (!q_put(t, dl)) r.status = dsq_pkg::ST_FULL;
            end
            default: ;
        endcase
        r.count = CNT_W'(sq_fill);
        if (sq_fill > 0) begin
            r.head_valid    = 1'b1;
            r.head_tag      = sq_tag[0];
            r.head_deadline = sq_dl[0];
        end
        return r;
    endfunction

    function automatic void add_step(input logic [FUNC_W-1:0] f,
                                     input logic [TAG_PORT_W-1:0] tg,
                                     input logic [DL_W-1:0] dl);
        t_sched_step s;
        s.func = f;
        s.tag = tg;
        s.deadline = dl;
        s.typed = 1'b0;
        s.want = '0;
        dir_steps.push_back(s);
    endfunction

    // Row with its result typed in; head_valid follows from the count
    function automatic void add_typed(input logic [FUNC_W-1:0] f,
                                      input logic [TAG_PORT_W-1:0] tg,
                                      input logic [DL_W-1:0] dl,
                                      input logic [STATUS_W-1:0] st,
                                      input int cnt,
                                      input logic [TAG_PORT_W-1:0] ht,
                                      input logic [DL_W-1:0] hd);
        t_sched_step s;
        s.func = f;
        s.tag = tg;
        s.deadline = dl;
        s.typed = 1'b1;
        s.want.status = st;
        s.want.count = CNT_W'(cnt);
        s.want.head_valid = (cnt != 0);
        s.want.head_tag = ht;
        s.want.head_deadline = hd;
        dir_steps.push_back(s);
    endfunction

    // Holds one request until it transfers, then idles at the sender's rate
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [TAG_PORT_W-1:0] tg,
                           input logic [DL_W-1:0] dl, input bit typed, input t_sched_rsp want);
        t_sched_rsp got;
        req_if.valid    <= 1'b1;
        req_if.func     <= f;
        req_if.tag      <= tg;
        req_if.deadline <= dl;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        got = apply_sched_op(f, tg, dl);
        predicted_rsp_q.push_back(typed ? want : got);
        op_seen[f]++;
        if (got.count == DEPTH) full_hits++;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_all_rsp();
        req_if.valid <= 1'b0;
        while (predicted_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: ready toggles at the current stall rate
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic check_field(input string fname, input logic [DL_W-1:0] want,
                               input logic [DL_W-1:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_sched_rsp want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            rsp_seen++;
            if (predicted_rsp_q.size() == 0) begin
                err_count++;
                $display("%0t: response with nothing outstanding, expected none, got %0h/%0d",
                         $time, rsp_if.status, rsp_if.count);
            end else begin
                want = predicted_rsp_q.pop_front();
                if (want.status == dsq_pkg::ST_FULL) full_drops++;
                if (want.status == dsq_pkg::ST_ABSENT) absent_seen++;
                check_field("status", want.status, rsp_if.status);
                check_field("count", want.count, rsp_if.count);
                check_field("head_valid", want.head_valid, rsp_if.head_valid);
                check_field("head_tag", want.head_tag, rsp_if.head_tag);
                check_field("head_deadline", want.head_deadline, rsp_if.head_deadline);
            end
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** deadline_sorted_queue_unit: FAILED **");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_sched_step           s;
        logic [FUNC_W-1:0]     f;
        logic [TAG_PORT_W-1:0] tg;
        logic [DL_W-1:0]       dl;
        bit                    draining;
        int                    r;
        int                    n;

        draining = 1'b0;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.func     <= dsq_pkg::FN_INSERT;
        req_if.tag      <= '0;
        req_if.deadline <= '0;

        // Empty queue, extremes, ties, moves present and absent
        add_typed(dsq_pkg::FN_REMOVE, 8'h05, 64'd0,  dsq_pkg::ST_ABSENT, 0, 8'h00, 64'd0);
        add_typed(FN_NOP,             8'h5A, DL_MAX, dsq_pkg::ST_DONE,   0, 8'h00, 64'd0);
        add_typed(dsq_pkg::FN_INSERT, 8'hFF, DL_MAX, dsq_pkg::ST_DONE,   1, 8'hFF, DL_MAX);
        add_typed(dsq_pkg::FN_INSERT, 8'h00, 64'd0,  dsq_pkg::ST_DONE,   2, 8'h00, 64'd0);
        add_typed(dsq_pkg::FN_INSERT, 8'h12, 64'd0,  dsq_pkg::ST_DONE,   3, 8'h00, 64'd0);
        add_typed(dsq_pkg::FN_MOVE,   8'h00, 64'd5,  dsq_pkg::ST_DONE,   3, 8'h12, 64'd0);
        add_typed(dsq_pkg::FN_MOVE,   8'h77, 64'd1,  dsq_pkg::ST_ABSENT, 4, 8'h12, 64'd0);
        add_typed(dsq_pkg::FN_REMOVE, 8'h12, 64'd0,  dsq_pkg::ST_DONE,   3, 8'h77, 64'd1);
        add_typed(FN_NOP,             8'h00, 64'd0,  dsq_pkg::ST_DONE,   3, 8'h77, 64'd1);
        // fill up with repeated tags and tied deadlines
        for (n = 0; n < DEPTH - 3; n++)
            add_step(dsq_pkg::FN_INSERT, TAG_PORT_W'(8'h20 + n % 7), DL_W'(64'd100 + n / 2));
        // full queue cases
        add_typed(dsq_pkg::FN_INSERT, 8'hA0, 64'd2,  dsq_pkg::ST_FULL,   16, 8'h77, 64'd1);
        add_typed(dsq_pkg::FN_REMOVE, 8'hAA, 64'd0,  dsq_pkg::ST_ABSENT, 16, 8'h77, 64'd1);
        add_typed(dsq_pkg::FN_MOVE,   8'hAB, 64'd7,  dsq_pkg::ST_FULL,   16, 8'h77, 64'd1);
        add_typed(dsq_pkg::FN_MOVE,   8'hFF, 64'd0,  dsq_pkg::ST_DONE,   16, 8'hFF, 64'd0);
        add_typed(dsq_pkg::FN_REMOVE, 8'hFF, 64'd0,  dsq_pkg::ST_DONE,   15, 8'h77, 64'd1);

        src_idle_pct = 6;
        snk_idle_pct = 87;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_steps[k]) begin
            s = dir_steps[k];
            send_op(s.func, s.tag, s.deadline, s.typed, s.want);
        end
        wait_all_rsp();

        for (n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                wait_all_rsp();
                src_idle_pct = 87;
                snk_idle_pct = 6;
            end else if (n == 2 * N_RANDOM / 3) begin
                wait_all_rsp();
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            // alternate fill-up and drain stretches so both ends get hit
            if (!draining && sq_fill == DEPTH && $urandom_range(3) == 0) draining = 1'b1;
            if (draining && sq_fill == 0 && $urandom_range(2) == 0) draining = 1'b0;

            r = $urandom_range(99);
            if (!draining)
                f = (r < 55) ? dsq_pkg::FN_INSERT : (r < 80) ? dsq_pkg::FN_MOVE :
                    (r < 95) ? dsq_pkg::FN_REMOVE : FN_NOP;
            else
                f = (r < 60) ? dsq_pkg::FN_REMOVE : (r < 75) ? dsq_pkg::FN_INSERT :
                    (r < 95) ? dsq_pkg::FN_MOVE : FN_NOP;

            // mostly tags already held, so removes and moves find their target
            r = $urandom_range(99);
            if (sq_fill > 0 && r < 60)
                tg = sq_tag[$urandom_range(sq_fill - 1)];
            else if (r < 80)
                tg = TAG_PORT_W'($urandom_range(7));
            else
                tg = TAG_PORT_W'($urandom_range(255));

            case ($urandom_range(9))
                0, 1, 2, 3: dl = DL_W'($urandom_range(15));
                4, 5, 6:    dl = {$urandom, $urandom};
                7:          dl = $urandom_range(1) ? DL_MAX : 64'd0;
                default:    dl = (sq_fill > 0) ? sq_dl[$urandom_range(sq_fill - 1)] : 64'd7;
            endcase

            send_op(f, tg, dl, 1'b0, '0);
        end

        wait_all_rsp();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d directed and %0d random operations:", dir_steps.size(), N_RANDOM);
        $display("  insert %0d, remove %0d, move %0d, no-op %0d.",
                 op_seen[dsq_pkg::FN_INSERT], op_seen[dsq_pkg::FN_REMOVE],
                 op_seen[dsq_pkg::FN_MOVE], op_seen[FN_NOP]);
        $display("Checked %0d responses: %0d full drops, %0d absent tags, queue full %0d times.",
                 rsp_seen, full_drops, absent_seen, full_hits);
        if (err_count == 0) begin
            $display("** deadline_sorted_queue_unit: PASSED **");
        end else begin
            $display("** deadline_sorted_queue_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dsq_pkg.sv
sv/dsq_req_if.sv
sv/dsq_rsp_if.sv
sv/dsq_store.sv
sv/dsq_cmp.sv
sv/deadline_sorted_queue_unit.sv
sim/tb_top.sv
